### rtl/plcr_pkg.sv
// Package for the piecewise linear clock recovery block.
// Holds payload structs, op and register codes, and the shared unit's request/response types.
// No dependencies.
package plcr_pkg;

  localparam int unsigned TsWidth  = 64;
  localparam int unsigned CfgWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [TsWidth-1:0] ALL_ONES   = '1;
  localparam logic [TsWidth-1:0] NS_PER_SEC = 64'd1_000_000_000;

  // Op codes of an input item
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_FREEZE  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_TICK_NUM   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_TICK_DENOM = 2'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic [TsWidth-1:0] system_time;
    logic [TsWidth-1:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic [TsWidth-1:0] timestamp;
    logic               held;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxWidth-1:0] index;
    logic [CfgWidth-1:0]    value;
  } cfg_wr_t;

  // Request to the shared multiply-divide unit: round(a*b/c), or low half of a*b
  typedef struct packed {
    logic               start;
    logic               mul_only;
    logic [TsWidth-1:0] a;
    logic [TsWidth-1:0] b;
    logic [TsWidth-1:0] c;
  } mdu_req_t;

  typedef struct packed {
    logic               done;
    logic [TsWidth-1:0] result;
  } mdu_rsp_t;

endpackage

### rtl/plcr_ifs.sv
// Valid/ready channel interfaces of the clock recovery block: input items,
// results and configuration writes. Depends on plcr_pkg.
interface plcr_in_if;
  logic                valid;
  logic                ready;
  plcr_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plcr_out_if;
  logic                valid;
  logic                ready;
  plcr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plcr_cfg_if;
  logic                valid;
  logic                ready;
  plcr_pkg::cfg_wr_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/plcr_mdu.sv
// Shared multiply-divide unit: 64x64 product from four 32x32 partial products,
// half-up rounding and a 64-step restoring division. Depends on plcr_pkg.
module plcr_mdu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plcr_pkg::mdu_req_t req_i,
  output plcr_pkg::mdu_rsp_t rsp_o
);

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_RND, U_CHK, U_DIV} ustate_e;

  localparam int unsigned W = plcr_pkg::TsWidth;
  localparam int unsigned H = W / 2;

  ustate_e            ustate_q;
  logic [5:0]         cnt_q;
  logic [2*W-1:0]     acc_q;
  logic [W-1:0]       a_q, b_q, c_q;
  logic               mul_only_q;
  logic [W-1:0]       pp_q;
  logic [1:0]         sh_q;
  plcr_pkg::mdu_rsp_t rsp_q;

  logic [H-1:0]   a_half, b_half;
  logic [W-1:0]   prod;
  logic [2*W-1:0] pp_aligned, acc_sum, rnd_sum, acc_shift;
  logic [W:0]     div_top, div_diff;
  logic           div_ge, ovf;
  logic [W-1:0]   div_rem;
  logic           rsp_done_d;

  // Partial product select and multiply
  assign a_half = cnt_q[1] ? a_q[W-1:H] : a_q[H-1:0];
  assign b_half = cnt_q[0] ? b_q[W-1:H] : b_q[H-1:0];
  assign prod   = W'(a_half) * W'(b_half);

  // Align the registered partial product and accumulate
  always_comb begin
    case (sh_q)
      2'd0:    pp_aligned = {{W{1'b0}}, pp_q};
      2'd1:    pp_aligned = {{H{1'b0}}, pp_q, {H{1'b0}}};
      default: pp_aligned = {pp_q, {W{1'b0}}};
    endcase
  end
  assign acc_sum = acc_q + pp_aligned;

  // Half-up rounding term and overflow check
  assign rnd_sum = acc_q + {{W{1'b0}}, 1'b0, c_q[W-1:1]};
  assign ovf     = (c_q == '0) || (acc_q[2*W-1:W] >= c_q);

  // One restoring division step: remainder in the upper half, quotient shifts in below
  assign div_top   = acc_q[2*W-1:W-1];
  assign div_diff  = div_top - {1'b0, c_q};
  assign div_ge    = div_top >= {1'b0, c_q};
  assign div_rem   = div_ge ? div_diff[W-1:0] : div_top[W-1:0];
  assign acc_shift = {div_rem, acc_q[W-2:0], div_ge};

  // Response strobe: product only, saturated scale or last quotient bit
  assign rsp_done_d = (ustate_q == U_MUL && cnt_q[2:0] == 3'd4 && mul_only_q) ||
                      (ustate_q == U_CHK && ovf) ||
                      (ustate_q == U_DIV && cnt_q == 6'd63);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ustate_q   <= U_IDLE;
      cnt_q      <= '0;
      acc_q      <= '0;
      a_q        <= '0;
      b_q        <= '0;
      c_q        <= '0;
      mul_only_q <= 1'b0;
      pp_q       <= '0;
      sh_q       <= '0;
      rsp_q      <= '0;
    end else begin
      rsp_q.done <= rsp_done_d;
      case (ustate_q)
        U_IDLE: begin
          if (req_i.start) begin
            a_q        <= req_i.a;
            b_q        <= req_i.b;
            c_q        <= req_i.c;
            mul_only_q <= req_i.mul_only;
            acc_q      <= '0;
            cnt_q      <= '0;
            ustate_q   <= U_MUL;
          end
        end
        U_MUL: begin
          if (cnt_q[2:0] != 3'd0) begin
            acc_q <= acc_sum;
          end
          if (cnt_q[2:0] != 3'd4) begin
            pp_q  <= prod;
            sh_q  <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
            cnt_q <= cnt_q + 6'd1;
          end else if (mul_only_q) begin
            rsp_q.result <= acc_sum[W-1:0];
            ustate_q     <= U_IDLE;
          end else begin
            ustate_q <= U_RND;
          end
        end
        U_RND: begin
          acc_q    <= rnd_sum;
          ustate_q <= U_CHK;
        end
        U_CHK: begin
          if (ovf) begin
            rsp_q.result <= plcr_pkg::ALL_ONES;
            ustate_q     <= U_IDLE;
          end else begin
            cnt_q    <= '0;
            ustate_q <= U_DIV;
          end
        end
        U_DIV: begin
          acc_q <= acc_shift;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            rsp_q.result <= acc_shift[W-1:0];
            ustate_q     <= U_IDLE;
          end
        end
        default: ustate_q <= U_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule

### rtl/piecewise_linear_clock_recovery.sv
// Piecewise linear clock recovery: rebuilds a driver clock from observations and
// answers time queries. One item is taken at a time; how long an extrapolating query
// or an observe holds the input is set by the shared multiply-divide unit (partial
// products, rounding, overflow check, then one quotient bit a cycle), which an observe
// uses twice, first for the tick product alone. A scale that overflows skips the
// quotient steps. A query while frozen goes straight to the output step, and a freeze
// is applied without leaving idle. Results wait in an output register so the next item
// can be taken while a result is still pending; a further query result waits until
// that register has been taken downstream.
// Depends on plcr_pkg, plcr_ifs and plcr_mdu.
module piecewise_linear_clock_recovery (
  input  logic        clk_i,
  input  logic        rst_ni,
  plcr_in_if.sink     in_i,
  plcr_out_if.source  res_o,
  plcr_cfg_if.sink    cfg_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_TMUL, S_OBS, S_OAPPLY, S_QRY, S_QCMP, S_EMIT
  } state_e;

  localparam int unsigned W  = plcr_pkg::TsWidth;
  localparam int unsigned CW = plcr_pkg::CfgWidth;

  state_e             state_q;
  logic [CW-1:0]      tick_num_q, tick_denom_q;
  logic [W-1:0]       rate_num_q, rate_den_q;
  logic [W-1:0]       prev_drv_q, prev_sys_q;
  logic [W-1:0]       drv_off_q, sys_off_q, cont_off_q;
  logic               extrap_q;
  logic [W-1:0]       last_out_q;
  logic [W-1:0]       now_q, val_q;
  logic [W-1:0]       res_ts_q;
  logic               res_held_q;
  logic               out_valid_q;
  plcr_pkg::out_item_t out_q;
  plcr_pkg::mdu_req_t mdu_req_q;
  plcr_pkg::mdu_rsp_t mdu_rsp;
  logic               in_xfer;
  logic               mdu_start;

  plcr_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req_q),
    .rsp_o  (mdu_rsp)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // Start strobe for the shared unit: observe, extrapolating query, second observe pass
  assign mdu_start = (in_xfer && (in_i.data.op == plcr_pkg::OP_OBSERVE ||
                                  (in_i.data.op == plcr_pkg::OP_QUERY && extrap_q))) ||
                     (state_q == S_TMUL && mdu_rsp.done);

  // Sequencer, clock state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tick_num_q   <= CW'(1);
      tick_denom_q <= CW'(1);
      rate_num_q   <= W'(1);
      rate_den_q   <= W'(1);
      prev_drv_q   <= plcr_pkg::ALL_ONES;
      prev_sys_q   <= plcr_pkg::ALL_ONES;
      drv_off_q    <= '0;
      sys_off_q    <= '0;
      cont_off_q   <= '0;
      extrap_q     <= 1'b0;
      last_out_q   <= '0;
      now_q        <= '0;
      val_q        <= '0;
      res_ts_q     <= '0;
      res_held_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      mdu_req_q    <= '0;
    end else begin
      mdu_req_q.start <= mdu_start;

      // Register writes
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          plcr_pkg::CFG_TICK_NUM:   tick_num_q   <= cfg_i.data.value;
          plcr_pkg::CFG_TICK_DENOM: tick_denom_q <= cfg_i.data.value;
          default: ;
        endcase
      end

      // Result taken downstream; in S_EMIT the output register is reloaded instead
      if (out_valid_q && res_o.ready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_i.data.op)
              plcr_pkg::OP_OBSERVE: begin
                // ticks * num, low 64 bits
                now_q              <= in_i.data.system_time;
                mdu_req_q.mul_only <= 1'b1;
                mdu_req_q.a        <= in_i.data.tick_count;
                mdu_req_q.b        <= {{(W-CW){1'b0}}, tick_num_q};
                mdu_req_q.c        <= plcr_pkg::ALL_ONES;
                state_q            <= S_TMUL;
              end
              plcr_pkg::OP_QUERY: begin
                if (extrap_q) begin
                  mdu_req_q.mul_only <= 1'b0;
                  mdu_req_q.a        <= in_i.data.system_time - sys_off_q;
                  mdu_req_q.b        <= rate_num_q;
                  mdu_req_q.c        <= rate_den_q;
                  state_q            <= S_QRY;
                end else begin
                  res_ts_q   <= last_out_q;
                  res_held_q <= 1'b1;
                  state_q    <= S_EMIT;
                end
              end
              plcr_pkg::OP_FREEZE: begin
                extrap_q   <= 1'b0;
                prev_drv_q <= plcr_pkg::ALL_ONES;
                prev_sys_q <= plcr_pkg::ALL_ONES;
              end
              default: ;
            endcase
          end
        end
        S_TMUL: begin
          // Scale the wrapped product to nanoseconds
          if (mdu_rsp.done) begin
            mdu_req_q.mul_only <= 1'b0;
            mdu_req_q.a        <= mdu_rsp.result;
            mdu_req_q.b        <= plcr_pkg::NS_PER_SEC;
            mdu_req_q.c        <= {{(W-CW){1'b0}}, tick_denom_q};
            state_q            <= S_OBS;
          end
        end
        S_OBS: begin
          if (mdu_rsp.done) begin
            val_q   <= mdu_rsp.result;
            state_q <= S_OAPPLY;
          end
        end
        S_OAPPLY: begin
          // Skip invalid conversions and repeated system times
          if (val_q != plcr_pkg::ALL_ONES && prev_sys_q != now_q) begin
            if (!extrap_q) begin
              // resume without a jump: offset collapses to last output time
              cont_off_q <= last_out_q - val_q;
              drv_off_q  <= last_out_q;
              extrap_q   <= 1'b1;
            end else begin
              drv_off_q <= val_q + cont_off_q;
            end
            if (prev_drv_q != plcr_pkg::ALL_ONES) begin
              rate_num_q <= val_q - prev_drv_q;
              rate_den_q <= now_q - prev_sys_q;
            end
            sys_off_q  <= now_q;
            prev_drv_q <= val_q;
            prev_sys_q <= now_q;
          end
          state_q <= S_IDLE;
        end
        S_QRY: begin
          if (mdu_rsp.done) begin
            val_q   <= mdu_rsp.result + drv_off_q;
            state_q <= S_QCMP;
          end
        end
        S_QCMP: begin
          // Monotonic hold
          if (last_out_q != plcr_pkg::ALL_ONES && last_out_q > val_q) begin
            res_ts_q   <= last_out_q;
            res_held_q <= 1'b1;
          end else begin
            last_out_q <= val_q;
            res_ts_q   <= val_q;
            res_held_q <= 1'b0;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q     <= 1'b1;
            out_q.timestamp <= res_ts_q;
            out_q.held      <= res_held_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The shared unit only answers while the sequencer waits on it
  a_mdu_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_rsp.done |-> (state_q == S_TMUL || state_q == S_OBS || state_q == S_QRY))
    else $error("multiply-divide result with no waiting step");

  // An observe transfer starts the tick product
  a_observe_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.data.op == plcr_pkg::OP_OBSERVE) |=>
      (state_q == S_TMUL && mdu_req_q.start))
    else $error("observe did not start the tick product");

  // Previous observation is forgotten as a pair
  a_prev_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prev_drv_q == plcr_pkg::ALL_ONES) |-> (prev_sys_q == plcr_pkg::ALL_ONES))
    else $error("previous driver time invalid without system time");

endmodule
